// ----- hdl/wws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wws_pkg: shared types and codes of the weighted descriptor splitter
// Word layouts of both channels, result kind codes and default parameter
// values.
// ----------------------------------------------------------------------------
package wws_pkg;

  localparam int unsigned DEF_NUM_QUEUE_PAIRS = 256;
  localparam int unsigned DEF_NUM_GROUPS      = 4;
  localparam int unsigned NUM_GRAN_REGS       = 4;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned GRAN_W    = 16;
  localparam int unsigned BUDGET_W  = 24;
  localparam int unsigned USED_W    = 25;
  localparam int unsigned PTR_W     = 32;
  localparam int unsigned PIECE_W   = 8;

  localparam logic [GRAN_W-1:0] GRAN_RESET = 16'd1024;

  localparam logic        KIND_DOORBELL = 1'b0;
  localparam logic        KIND_DESC     = 1'b1;

  localparam logic [1:0]  QP_LATENCY = 2'd0;

  localparam logic [1:0]  RES_PIECE    = 2'd0;
  localparam logic [1:0]  RES_SUMMARY  = 2'd1;
  localparam logic [1:0]  RES_DOORBELL = 2'd2;

  localparam logic [PIECE_W-1:0] PIECE_MAX = 8'd255;

  typedef struct packed {
    logic        kind;
    logic [7:0]  qp_index;
    logic [1:0]  qp_type;
    logic [7:0]  qp_weight;
    logic [1:0]  qp_group;
    logic        last_in_batch;
    logic [31:0] length_or_count;
    logic [63:0] local_addr;
    logic [31:0] remote_addr_low;
    logic [4:0]  op_code;
    logic        signaled_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_qp;
    logic [4:0]  out_op_code;
    logic [63:0] sub_local_addr;
    logic [31:0] sub_remote_addr_low;
    logic [31:0] sub_length;
    logic        sub_signaled;
    logic        high_priority;
    logic [7:0]  piece_count;
    logic        requeue;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] offset;
  } entry_t;

endpackage

// ----- hdl/weighted_wqe_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_wqe_splitter: per queue pair doorbell handling and descriptor split
// Keeps head, tail and byte offset per queue pair, answers doorbells and cuts
// fetched descriptors into pieces that fit the weighted batch budget.
// ----------------------------------------------------------------------------
// An input word is taken into the input register together with a read of its
// queue pair entry from the pointer table, which has one read and one write
// port; from the input register the result words are formed and written into
// a two word output buffer while the updated entry is written back, with
// forwarding to a following word of the same queue pair. One word per cycle
// is sustained while each word gives one result or none and the receiver takes
// every result as offered; a word that closes a batch with a piece gives two
// results and holds the next word until the second is taken. The table needs
// no clearing pass: a valid flag per entry, cleared by reset, makes an
// unwritten entry read as zero.
module weighted_wqe_splitter
  import wws_pkg::*;
#(
  parameter int unsigned NUM_QUEUE_PAIRS = DEF_NUM_QUEUE_PAIRS,
  parameter int unsigned NUM_GROUPS      = DEF_NUM_GROUPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GRAN_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output res_t                 out_data_o
);

  localparam int unsigned MEM_DEPTH = (NUM_QUEUE_PAIRS < 256) ? NUM_QUEUE_PAIRS : 256;
  localparam int unsigned QW        = $clog2(MEM_DEPTH);
  localparam int unsigned NG        = (NUM_GROUPS < NUM_GRAN_REGS) ? NUM_GROUPS
                                                                   : NUM_GRAN_REGS;
  localparam int unsigned GW        = (NG > 1) ? $clog2(NG) : 1;

  logic [QW-1:0]       qmod_lut [256];
  logic [GRAN_W-1:0]   gran_q [NG];
  logic [GRAN_W-1:0]   gran_sel;
  logic [BUDGET_W-1:0] budget_d;
  logic [QW-1:0]       in_idx;
  logic                in_acc;

  logic                s1_valid_q;
  in_t                 s1_q;
  logic [QW-1:0]       s1_idx_q;
  logic [BUDGET_W-1:0] budget_q;
  logic                s1_adv;

  entry_t              mem [MEM_DEPTH];
  entry_t              rd_data_q;
  logic                rd_valid_q;
  logic [MEM_DEPTH-1:0] valid_q;
  logic                byp_valid_q;
  entry_t              byp_data_q;
  entry_t              cur;
  entry_t              ent_d;

  logic                batch_open_q, batch_open_d;
  logic                batch_dropping_q, batch_dropping_d;
  logic [USED_W-1:0]   batch_used_q, batch_used_d;
  logic [PIECE_W-1:0]  batch_pieces_q, batch_pieces_d;

  logic                lat;
  logic                piece_v;
  logic                sum_v;
  logic                done;
  logic [31:0]         rem;
  logic [31:0]         space;
  logic [31:0]         sub;
  res_t                piece;
  res_t                summ;
  res_t                res0, res1;
  logic [1:0]          nres;

  res_t                slot_q [2];
  logic [1:0]          cnt_q;
  logic                pop;

  for (genvar i = 0; i < 256; i++) begin : g_qmod
    assign qmod_lut[i] = QW'(i % NUM_QUEUE_PAIRS);
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NG; g++) begin
        gran_q[g] <= GRAN_RESET;
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NG))) begin
      gran_q[cfg_index_i[GW-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    if (int'(in_data_i.qp_group) < NG) begin
      gran_sel = gran_q[in_data_i.qp_group[GW-1:0]];
    end else begin
      gran_sel = gran_q[0];
    end
  end

  assign budget_d   = in_data_i.qp_weight * gran_sel;
  assign in_idx     = qmod_lut[in_data_i.qp_index];
  assign pop        = out_valid_o && out_ready_i;
  assign s1_adv     = s1_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i));
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q  <= 1'b1;
      byp_valid_q <= s1_adv && (s1_idx_q == in_idx);
      rd_valid_q  <= valid_q[in_idx];
    end else if (s1_adv) begin
      s1_valid_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q       <= in_data_i;
      s1_idx_q   <= in_idx;
      budget_q   <= budget_d;
      byp_data_q <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem[s1_idx_q] <= ent_d;
    end
    if (in_acc) begin
      rd_data_q <= mem[in_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (s1_adv) begin
      valid_q[s1_idx_q] <= 1'b1;
    end
  end

  always_comb begin
    if (byp_valid_q) begin
      cur = byp_data_q;
    end else if (rd_valid_q) begin
      cur = rd_data_q;
    end else begin
      cur = '0;
    end
  end

  assign lat = (s1_q.qp_type == QP_LATENCY);

  always_comb begin
    ent_d            = cur;
    batch_open_d     = batch_open_q;
    batch_dropping_d = batch_dropping_q;
    batch_used_d     = batch_used_q;
    batch_pieces_d   = batch_pieces_q;
    piece_v          = 1'b0;
    sum_v            = 1'b0;
    done             = 1'b0;
    rem              = '0;
    space            = '0;
    sub              = '0;
    piece            = '0;
    summ             = '0;
    res0             = '0;
    res1             = '0;
    nres             = 2'd0;
    piece.result_kind = RES_PIECE;
    piece.out_qp      = s1_q.qp_index;
    piece.out_op_code = s1_q.op_code;
    summ.result_kind  = RES_SUMMARY;
    summ.out_qp       = s1_q.qp_index;
    summ.high_priority = lat;
    summ.last          = 1'b1;
    if (s1_q.kind == KIND_DOORBELL) begin
      ent_d.head          = cur.head + s1_q.length_or_count;
      res0.result_kind    = RES_DOORBELL;
      res0.out_qp         = s1_q.qp_index;
      res0.high_priority  = lat;
      res0.requeue        = lat || (cur.head == cur.tail);
      res0.last           = 1'b1;
      nres                = 2'd1;
    end else begin
      if (!batch_open_q) begin
        batch_open_d     = 1'b1;
        batch_used_d     = '0;
        batch_pieces_d   = '0;
        batch_dropping_d = (cur.head == cur.tail);
      end
      if (!batch_dropping_d) begin
        if (lat) begin
          piece_v              = 1'b1;
          piece.sub_local_addr = s1_q.local_addr;
          piece.sub_remote_addr_low = s1_q.remote_addr_low;
          piece.sub_length     = s1_q.length_or_count;
          piece.sub_signaled   = s1_q.signaled_in;
          piece.high_priority  = 1'b1;
          ent_d.tail           = cur.tail + 32'd1;
        end else if (batch_used_d < {1'b0, budget_q}) begin
          piece_v = 1'b1;
          rem     = (s1_q.length_or_count > cur.offset) ? (s1_q.length_or_count - cur.offset)
                                                        : '0;
          space   = 32'({1'b0, budget_q} - batch_used_d);
          sub     = (rem > space) ? space : rem;
          done    = (sub == rem);
          piece.sub_local_addr      = s1_q.local_addr + 64'(cur.offset);
          piece.sub_remote_addr_low = s1_q.remote_addr_low + cur.offset;
          piece.sub_length          = sub;
          if (done) begin
            piece.sub_signaled = s1_q.signaled_in;
            ent_d.tail         = cur.tail + 32'd1;
            ent_d.offset       = '0;
          end else begin
            ent_d.offset       = cur.offset + sub;
          end
          batch_used_d = batch_used_d + USED_W'(sub);
        end
        if (piece_v && (batch_pieces_d != PIECE_MAX)) begin
          batch_pieces_d = batch_pieces_d + 8'd1;
        end
      end
      if (s1_q.last_in_batch) begin
        sum_v             = !batch_dropping_d;
        summ.piece_count  = batch_pieces_d;
        summ.requeue      = !lat && (ent_d.tail != ent_d.head);
        batch_open_d      = 1'b0;
        batch_dropping_d  = 1'b0;
        batch_used_d      = '0;
        batch_pieces_d    = '0;
      end
      piece.last = !sum_v;
      if (piece_v) begin
        res0 = piece;
        res1 = summ;
        nres = sum_v ? 2'd2 : 2'd1;
      end else begin
        res0 = summ;
        nres = sum_v ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_open_q     <= 1'b0;
      batch_dropping_q <= 1'b0;
      batch_used_q     <= '0;
      batch_pieces_q   <= '0;
    end else if (s1_adv) begin
      batch_open_q     <= batch_open_d;
      batch_dropping_q <= batch_dropping_d;
      batch_used_q     <= batch_used_d;
      batch_pieces_q   <= batch_pieces_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (s1_adv) begin
      cnt_q <= nres;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      slot_q[0] <= res0;
      slot_q[1] <= res1;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];

`ifndef NO_ASSERTIONS
  a_single_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> slot_q[0].last)
    else $error("A lone buffered word is not marked last.");

  a_pair_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!slot_q[0].last && slot_q[1].last &&
                         (slot_q[1].result_kind == RES_SUMMARY)))
    else $error("A buffered pair is not a piece followed by its summary.");

  a_drop_in_batch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_dropping_q |-> batch_open_q)
    else $error("Dropping is set outside an open batch.");

  a_piece_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && piece_v && !lat) |-> (piece.sub_length <= 32'(budget_q)))
    else $error("A piece exceeds the batch budget.");
`endif

endmodule

// ----- tb/splitter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitter_checker: result predictor and comparator for the descriptor splitter
// Watches the configuration, input and result channels of the splitter. Every
// accepted input word is run through a behavioural copy of the per queue pair
// pointer tables and the batch budget logic, and the results it must cause are
// queued in order. Every accepted result word is compared field by field with
// the oldest queued result. Mismatches and unexpected results are counted and
// the count is handed to the testbench top.
// ----------------------------------------------------------------------------
module splitter_checker
  import wws_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GRAN_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  res_t                 out_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          results_pending_o
);

  localparam int unsigned QP_COUNT = DEF_NUM_QUEUE_PAIRS;
  localparam int unsigned GRAN_IW  = $clog2(NUM_GRAN_REGS);

  logic [GRAN_W-1:0] granularity [NUM_GRAN_REGS];
  logic [PTR_W-1:0]  qp_head     [QP_COUNT];
  logic [PTR_W-1:0]  qp_tail     [QP_COUNT];
  logic [PTR_W-1:0]  byte_offset [QP_COUNT];
  logic [31:0]       bytes_used;
  logic [PIECE_W-1:0] pieces;
  bit                batch_open;
  bit                batch_dropping;

  res_t pending_results [$];

  initial begin
    fail_count_o      = 0;
    results_pending_o = 0;
  end

  task automatic report(input string what);
    $display("splitter_checker: %0t: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic clear_state();
    for (int i = 0; i < NUM_GRAN_REGS; i++) granularity[i] = GRAN_RESET;
    for (int i = 0; i < QP_COUNT; i++) begin
      qp_head[i]     = '0;
      qp_tail[i]     = '0;
      byte_offset[i] = '0;
    end
    bytes_used     = '0;
    pieces         = '0;
    batch_open     = 1'b0;
    batch_dropping = 1'b0;
    pending_results.delete();
  endtask

  function automatic res_t blank_result(input logic [1:0] kind, input logic [7:0] qp,
                                        input bit hp);
    res_t r;
    r               = '0;
    r.result_kind   = kind;
    r.out_qp        = qp;
    r.high_priority = hp;
    return r;
  endfunction

  task automatic count_piece();
    if (pieces < PIECE_MAX) pieces++;
  endtask

  task automatic split_word(input in_t w);
    res_t        r [2];
    int          n;
    logic [7:0]  q;
    bit          lat;
    logic [31:0] budget;
    logic [31:0] off;
    logic [31:0] rem;
    logic [31:0] space;
    logic [31:0] sub;
    n   = 0;
    q   = w.qp_index;
    lat = (w.qp_type == QP_LATENCY);
    if (w.kind == KIND_DOORBELL) begin
      r[0]         = blank_result(RES_DOORBELL, q, lat);
      r[0].requeue = lat || (qp_head[q] == qp_tail[q]);
      qp_head[q]   = qp_head[q] + w.length_or_count;
      n            = 1;
    end else begin
      if (!batch_open) begin
        batch_open     = 1'b1;
        bytes_used     = '0;
        pieces         = '0;
        batch_dropping = (qp_head[q] == qp_tail[q]);
      end
      if (!batch_dropping) begin
        if (lat) begin
          r[0]                     = blank_result(RES_PIECE, q, 1'b1);
          r[0].out_op_code         = w.op_code;
          r[0].sub_local_addr      = w.local_addr;
          r[0].sub_remote_addr_low = w.remote_addr_low;
          r[0].sub_length          = w.length_or_count;
          r[0].sub_signaled        = w.signaled_in;
          qp_tail[q]               = qp_tail[q] + 32'd1;
          count_piece();
          n = 1;
        end else begin
          budget = 32'(w.qp_weight) * 32'(granularity[w.qp_group]);
          if (bytes_used < budget) begin
            off   = byte_offset[q];
            rem   = (w.length_or_count > off) ? w.length_or_count - off : 32'd0;
            space = budget - bytes_used;
            sub   = (rem > space) ? space : rem;
            r[0]                     = blank_result(RES_PIECE, q, 1'b0);
            r[0].out_op_code         = w.op_code;
            r[0].sub_local_addr      = w.local_addr + 64'(off);
            r[0].sub_remote_addr_low = w.remote_addr_low + off;
            r[0].sub_length          = sub;
            if (sub == rem) begin
              r[0].sub_signaled = w.signaled_in;
              qp_tail[q]        = qp_tail[q] + 32'd1;
              byte_offset[q]    = '0;
            end else begin
              byte_offset[q] = off + sub;
            end
            bytes_used = bytes_used + sub;
            count_piece();
            n = 1;
          end
        end
      end
      if (w.last_in_batch) begin
        if (!batch_dropping) begin
          r[n]             = blank_result(RES_SUMMARY, q, lat);
          r[n].piece_count = pieces;
          r[n].requeue     = !lat && (qp_tail[q] != qp_head[q]);
          n++;
        end
        batch_open     = 1'b0;
        batch_dropping = 1'b0;
        bytes_used     = '0;
        pieces         = '0;
      end
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(r[i]);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result word for qp %0d with nothing expected", got.out_qp));
    end else begin
      want = pending_results.pop_front();
      check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
      check_field("out_qp", 64'(got.out_qp), 64'(want.out_qp));
      check_field("out_op_code", 64'(got.out_op_code), 64'(want.out_op_code));
      check_field("sub_local_addr", got.sub_local_addr, want.sub_local_addr);
      check_field("sub_remote_addr_low", 64'(got.sub_remote_addr_low),
                  64'(want.sub_remote_addr_low));
      check_field("sub_length", 64'(got.sub_length), 64'(want.sub_length));
      check_field("sub_signaled", 64'(got.sub_signaled), 64'(want.sub_signaled));
      check_field("high_priority", 64'(got.high_priority), 64'(want.high_priority));
      check_field("piece_count", 64'(got.piece_count), 64'(want.piece_count));
      check_field("requeue", 64'(got.requeue), 64'(want.requeue));
      check_field("last", 64'(got.last), 64'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_valid_i && cfg_ready_i && (cfg_index_i < NUM_GRAN_REGS)) begin
        granularity[cfg_index_i[GRAN_IW-1:0]] = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) split_word(in_data_i);
    end
    results_pending_o = pending_results.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the weighted descriptor splitter
// Drives doorbell and descriptor words into the splitter: a directed opening
// covering dropped batches, exhausted budgets, zero weight, offsets beyond the
// message, pointer wrap and the unused queue pair type, then randomised
// doorbell and fetch batch sequences mixed with broken batches and noise over
// several granularity settings. Both sides idle at random, the receiver holds
// off once for a long stretch, and the checker beside the splitter predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import wws_pkg::*;

  localparam logic [1:0] QP_BANDWIDTH = 2'd1;
  localparam logic [1:0] QP_DATAGRAM  = 2'd2;
  localparam logic [1:0] QP_SPARE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRAN_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAN_1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAN_2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAN_3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 4'd15;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PERCENT  = 29;
  localparam int unsigned HOLD_CYCLES   = 300;

  localparam logic [63:0] ADDR_TOP = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GRAN_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  res_t                 out_data;
  int unsigned          fail_count;
  int unsigned          results_pending;

  logic [GRAN_W-1:0] cur_gran [NUM_GRAN_REGS];
  int unsigned       words_sent;
  bit                quiet;
  int unsigned       rx_hold_req;

  weighted_wqe_splitter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  splitter_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .fail_count_o      (fail_count),
    .results_pending_o (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // The main process counts hold requests up; this process takes each new one.
  initial begin
    int unsigned hold_left;
    int unsigned hold_taken;
    hold_left  = 0;
    hold_taken = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = rx_hold_req;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  function automatic in_t mk(input logic kind, input logic [7:0] qp, input logic [1:0] ty,
                             input logic [7:0] wt, input logic [1:0] grp, input logic last,
                             input logic [31:0] len, input logic [63:0] la,
                             input logic [31:0] ra, input logic [4:0] op, input logic sig);
    in_t w;
    w.kind            = kind;
    w.qp_index        = qp;
    w.qp_type         = ty;
    w.qp_weight       = wt;
    w.qp_group        = grp;
    w.last_in_batch   = last;
    w.length_or_count = len;
    w.local_addr      = la;
    w.remote_addr_low = ra;
    w.op_code         = op;
    w.signaled_in     = sig;
    return w;
  endfunction

  function automatic in_t random_word();
    return mk(1'($urandom), 8'($urandom), 2'($urandom), 8'($urandom), 2'($urandom),
              1'($urandom), $urandom, {$urandom, $urandom}, $urandom, 5'($urandom),
              1'($urandom));
  endfunction

  function automatic logic [7:0] pick_qp();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 8'($urandom_range(0, 7));
    if (sel < 16) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_len(input logic [7:0] wt, input logic [1:0] grp);
    logic [31:0] budget;
    budget = 32'(wt) * 32'(cur_gran[grp]);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'd0;
      2:       return budget;
      default: return $urandom_range(0, budget * 2 + 16);
    endcase
  endfunction

  task automatic send_word(input in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    while (!quiet && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_pending == 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRAN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grans(input logic [GRAN_W-1:0] g0, input logic [GRAN_W-1:0] g1,
                           input logic [GRAN_W-1:0] g2, input logic [GRAN_W-1:0] g3);
    write_reg(REG_GRAN_0, g0);
    write_reg(REG_GRAN_1, g1);
    write_reg(REG_GRAN_2, g2);
    write_reg(REG_GRAN_3, g3);
    cur_gran[0] = g0;
    cur_gran[1] = g1;
    cur_gran[2] = g2;
    cur_gran[3] = g3;
  endtask

  // Mostly a doorbell followed by a closed fetch batch for the same queue
  // pair, with broken batches and stray words mixed in; an open batch is
  // closed at the end so that a new setting starts cleanly.
  task automatic run_segment(input int unsigned n_words);
    int unsigned start;
    int unsigned sel;
    int unsigned cnt;
    int unsigned nd;
    logic [7:0]  q;
    logic [1:0]  ty;
    logic [1:0]  grp;
    logic [7:0]  wt;
    in_t         w;
    start = words_sent;
    while (words_sent - start < n_words) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        q   = pick_qp();
        ty  = 2'($urandom_range(0, 3));
        grp = 2'($urandom_range(0, 3));
        wt  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(1, 8));
        w = random_word();
        w.kind      = KIND_DOORBELL;
        w.qp_index  = q;
        w.qp_type   = ty;
        w.qp_weight = wt;
        w.qp_group  = grp;
        if ($urandom_range(0, 9) == 0) w.length_or_count = $urandom;
        else w.length_or_count = $urandom_range(1, 6);
        cnt = (w.length_or_count > 6) ? 6 : w.length_or_count;
        send_word(w);
        nd = $urandom_range(1, cnt + 2);
        for (int i = 0; i < nd; i++) begin
          w = random_word();
          w.kind            = KIND_DESC;
          w.qp_index        = q;
          w.qp_type         = ty;
          w.qp_weight       = wt;
          w.qp_group        = grp;
          w.last_in_batch   = (i == nd - 1);
          w.length_or_count = pick_len(wt, grp);
          send_word(w);
        end
      end else if (sel < 17) begin
        repeat ($urandom_range(2, 6)) begin
          w = random_word();
          if ($urandom_range(0, 3) != 0) w.kind = KIND_DESC;
          w.qp_index      = pick_qp();
          w.last_in_batch = ($urandom_range(0, 3) == 0);
          send_word(w);
        end
      end else begin
        send_word(random_word());
      end
    end
    w = random_word();
    w.kind          = KIND_DESC;
    w.last_in_batch = 1'b1;
    send_word(w);
  endtask

  initial begin
    in_t w;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    rx_hold_req = 0;
    words_sent  = 0;
    for (int i = 0; i < NUM_GRAN_REGS; i++) cur_gran[i] = GRAN_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A batch that opens while head equals tail gives nothing at all.
    send_word(mk(KIND_DESC, 8'd2, QP_BANDWIDTH, 8'd1, 2'd0, 1'b0, 32'd100, 64'h10,
                 32'h20, 5'd1, 1'b0));
    send_word(mk(KIND_DESC, 8'd2, QP_BANDWIDTH, 8'd1, 2'd0, 1'b1, 32'd100, 64'h10,
                 32'h20, 5'd1, 1'b1));
    send_word(mk(KIND_DOORBELL, 8'd0, QP_LATENCY, 8'd1, 2'd0, 1'b0, 32'd2, '0, '0,
                 5'd0, 1'b0));
    send_word(mk(KIND_DOORBELL, 8'd1, QP_BANDWIDTH, 8'd1, 2'd0, 1'b0, 32'd3, '0, '0,
                 5'd0, 1'b0));
    send_word(mk(KIND_DOORBELL, 8'd1, QP_BANDWIDTH, 8'd1, 2'd0, 1'b0, 32'd1, '0, '0,
                 5'd0, 1'b0));
    // Latency pass-through with a doorbell arriving inside the open batch.
    send_word(mk(KIND_DESC, 8'd0, QP_LATENCY, 8'd1, 2'd0, 1'b0, 32'd0, ADDR_TOP,
                 '1, 5'd31, 1'b1));
    send_word(mk(KIND_DOORBELL, 8'd5, QP_DATAGRAM, 8'd1, 2'd0, 1'b0, 32'd1, '0, '0,
                 5'd0, 1'b0));
    send_word(mk(KIND_DESC, 8'd0, QP_LATENCY, 8'd1, 2'd0, 1'b1, '1, 64'h1234, 32'h5678,
                 5'd7, 1'b0));
    // Split against the budget, then a descriptor that finds it used up.
    send_word(mk(KIND_DESC, 8'd1, QP_BANDWIDTH, 8'd1, 2'd0, 1'b0, 32'd3000, ADDR_TOP,
                 32'hFFFF_FF00, 5'd3, 1'b1));
    send_word(mk(KIND_DESC, 8'd1, QP_BANDWIDTH, 8'd1, 2'd0, 1'b1, 32'd3000, ADDR_TOP,
                 32'hFFFF_FF00, 5'd3, 1'b1));
    // Resume at the stored offset, with the addresses wrapping.
    send_word(mk(KIND_DESC, 8'd1, QP_BANDWIDTH, 8'd1, 2'd1, 1'b0, 32'd3000, ADDR_TOP,
                 32'hFFFF_FF00, 5'd3, 1'b1));
    // The stored offset lies beyond this message: an empty finishing piece.
    send_word(mk(KIND_DESC, 8'd1, QP_BANDWIDTH, 8'd2, 2'd0, 1'b1, 32'd100, 64'h40,
                 32'h80, 5'd4, 1'b1));
    // Zero weight, then the spare type with the largest weight.
    send_word(mk(KIND_DESC, 8'd1, QP_SPARE, 8'd0, 2'd2, 1'b0, 32'd50, 64'h100,
                 32'h200, 5'd5, 1'b1));
    send_word(mk(KIND_DESC, 8'd1, QP_SPARE, 8'd255, 2'd3, 1'b1, 32'd5000, 64'h100,
                 32'h200, 5'd5, 1'b1));
    send_word(mk(KIND_DESC, 8'd5, QP_DATAGRAM, 8'd1, 2'd0, 1'b1, 32'd10, 64'h300,
                 32'h400, 5'd6, 1'b0));
    send_word(mk(KIND_DESC, 8'd5, QP_DATAGRAM, 8'd1, 2'd0, 1'b1, 32'd10, 64'h300,
                 32'h400, 5'd6, 1'b0));
    // Head wraps, then the tail runs past it.
    send_word(mk(KIND_DOORBELL, 8'd255, QP_LATENCY, 8'd1, 2'd0, 1'b0, '1, '0, '0,
                 5'd0, 1'b0));
    send_word(mk(KIND_DOORBELL, 8'd255, QP_LATENCY, 8'd1, 2'd0, 1'b0, 32'd2, '0, '0,
                 5'd0, 1'b0));
    send_word(mk(KIND_DESC, 8'd255, QP_LATENCY, 8'd1, 2'd0, 1'b0, 32'd7, 64'h8,
                 32'h9, 5'd2, 1'b1));
    send_word(mk(KIND_DESC, 8'd255, QP_LATENCY, 8'd1, 2'd0, 1'b0, 32'd7, 64'h8,
                 32'h9, 5'd2, 1'b0));
    send_word(mk(KIND_DESC, 8'd255, QP_LATENCY, 8'd1, 2'd0, 1'b1, 32'd7, 64'h8,
                 32'h9, 5'd2, 1'b1));
    send_word(mk(KIND_DOORBELL, 8'd255, QP_BANDWIDTH, 8'd1, 2'd0, 1'b0, 32'd0, '0, '0,
                 5'd0, 1'b0));

    // One long latency batch drives the piece count into saturation.
    send_word(mk(KIND_DOORBELL, 8'd9, QP_LATENCY, 8'd1, 2'd0, 1'b0, 32'd300, '0, '0,
                 5'd0, 1'b0));
    for (int i = 0; i < 260; i++) begin
      w = random_word();
      w.kind          = KIND_DESC;
      w.qp_index      = 8'd9;
      w.qp_type       = QP_LATENCY;
      w.last_in_batch = (i == 259);
      send_word(w);
    end
    run_segment(150);

    drain();
    set_grans(16'd1, 16'd1, 16'd1, 16'd1);
    write_reg(REG_SPARE, 16'($urandom));
    rx_hold_req++;
    run_segment(40);
    drain();
    run_segment(200);

    drain();
    set_grans(16'd65535, 16'd65535, 16'd65535, 16'd65535);
    quiet = 1'b1;
    run_segment(200);
    quiet = 1'b0;

    drain();
    set_grans(16'd16, 16'd64, 16'd3, 16'd200);
    run_segment(200);

    drain();
    set_grans(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    run_segment(200);

    drain();
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
